@@ rtl/core/sbv_pkg.sv @@
package sbv_pkg;

    // Default depth of the element stores.
    localparam int MAX_CHANNELS_DEF = 64;

    // Field widths.
    localparam int PROB_W = 16;
    localparam int GRAD_W = 16;
    localparam int OUT_W  = 16;

    // Probability is Q1.15, so a gradient is moved to the product scale by 15 bits.
    localparam int FRAC_SHIFT = 15;

    // Dot-product accumulator, Q.27.
    localparam int DOT_W = 40;

    // Shared multiplier: signed 25 x signed 17.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // The 40-bit difference is multiplied in two slices.
    localparam int LO_W = MUL_A_W - 1;
    localparam int HI_W = DOT_W - LO_W;

    // Full Q.42 product and the shift back to Q.12.
    localparam int SUM_W      = 58;
    localparam int OUT_SHIFT  = 30;
    localparam int SCALED_W   = SUM_W - OUT_SHIFT;
    localparam int ROUND_W    = SCALED_W + 1;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;

endpackage

@@ rtl/core/sbv_mul.sv @@
module sbv_mul (
    input  logic            clk,
    input  logic            en,
    input  sbv_pkg::mul_a_t a,
    input  sbv_pkg::mul_b_t b,
    output sbv_pkg::mul_p_t p
);
    import sbv_pkg::*;

    mul_p_t prod_reg;

    // Registered signed product, loaded only when the sequencer asks for it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mul_p_t'(a) * mul_p_t'(b);
        end
    end

    assign p = prod_reg;

endmodule

@@ rtl/core/softmax_backward_vector_unit.sv @@
// Channel   Handshake                   Payload
// item      item_valid / item_ready     prob, grad_in, last
// result    result_valid / result_ready grad_out, last_out, saturated
//
// A stored element is accepted, multiplied and accumulated in turn; an element
// beyond the store depth is dropped on acceptance. Each result is read, differenced,
// multiplied in two slices, summed, scaled and held until result_ready; the single
// shared 25x17 multiplier forms every product.
// rst_n clears the sequencer, the element count and the accumulator at once.
// The block takes no item while a vector's results are being produced.
module softmax_backward_vector_unit #(
    parameter int MAX_CHANNELS = sbv_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [sbv_pkg::PROB_W-1:0]        prob,
    input  logic signed [sbv_pkg::GRAD_W-1:0] grad_in,
    input  logic                              last,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [sbv_pkg::OUT_W-1:0]  grad_out,
    output logic                              last_out,
    output logic                              saturated
);
    import sbv_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int ADDR_W = $clog2(MAX_CHANNELS);

    localparam logic signed [ROUND_W-1:0] OUT_MAX = ROUND_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [ROUND_W-1:0] OUT_MIN = -ROUND_W'(2 ** (OUT_W - 1));

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_MLO   = 4'd5;
    localparam logic [3:0] S_MHI   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Control registers.
    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic                    last_reg, last_next;
    logic                    result_valid_reg, result_valid_next;

    // Payload registers.
    logic [PROB_W-1:0]        y_reg;
    logic signed [GRAD_W-1:0] g_reg;
    logic [PROB_W-1:0]        rd_prob_reg;
    logic signed [GRAD_W-1:0] rd_grad_reg;
    logic signed [DOT_W-1:0]  diff_reg;
    mul_p_t                   lo_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [OUT_W-1:0]  grad_out_reg;
    logic                     last_out_reg;
    logic                     sat_reg;

    // Element stores.
    logic [PROB_W-1:0]        prob_mem [MAX_CHANNELS];
    logic signed [GRAD_W-1:0] grad_mem [MAX_CHANNELS];

    logic   item_accept;
    logic   result_accept;
    logic   room;
    logic   store_en;
    logic   final_result;
    logic   mul_en;
    mul_a_t mul_a;
    mul_b_t mul_b;
    mul_p_t mul_p;

    logic signed [DOT_W-1:0]    grad_scaled;
    logic [SUM_W-1:0]           hi_ext;
    logic [SUM_W-1:0]           lo_ext;
    logic signed [SCALED_W-1:0] scaled;
    logic                       round_adj;
    logic signed [ROUND_W-1:0]  rounded;

    assign item_ready    = (state_reg == S_IDLE);
    assign item_accept   = item_valid && item_ready;
    assign result_accept = result_valid_reg && result_ready;
    assign room          = (count_reg < CNT_W'(MAX_CHANNELS));
    assign store_en      = item_accept && room;
    assign final_result  = ((idx_reg + CNT_W'(1)) == count_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = {1'b0, rd_prob_reg};
        case (state_reg)
            S_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_A_W - GRAD_W){g_reg[GRAD_W-1]}}, g_reg};
                mul_b  = {1'b0, y_reg};
            end
            S_MLO:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, diff_reg[LO_W-1:0]};
            end
            S_MHI:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MUL_A_W - HI_W){diff_reg[DOT_W-1]}}, diff_reg[DOT_W-1:LO_W]};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    sbv_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Datapath helpers: scaled gradient, slice recombination, rounding toward zero.
    assign grad_scaled = {{(DOT_W - GRAD_W - FRAC_SHIFT){rd_grad_reg[GRAD_W-1]}},
                          rd_grad_reg, {FRAC_SHIFT{1'b0}}};
    assign hi_ext      = {{(SUM_W - MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
    assign lo_ext      = {{(SUM_W - MUL_P_W){1'b0}}, lo_reg};
    assign scaled      = sum_reg[SUM_W-1:OUT_SHIFT];
    assign round_adj   = sum_reg[SUM_W-1] && (|sum_reg[OUT_SHIFT-1:0]);
    assign rounded     = {scaled[SCALED_W-1], scaled} + ROUND_W'(round_adj);

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        dot_next          = dot_reg;
        last_next         = last_reg;
        result_valid_next = result_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    last_next = last;
                    idx_next  = '0;
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_MUL;
                    end
                    else if (last)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                dot_next   = dot_reg + mul_p[DOT_W-1:0];
                state_next = last_reg ? S_RD : S_IDLE;
            end
            S_RD:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                state_next = S_MLO;
            end
            S_MLO:
            begin
                state_next = S_MHI;
            end
            S_MHI:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                result_valid_next = 1'b1;
                state_next        = S_OUT;
            end
            S_OUT:
            begin
                if (result_accept)
                begin
                    result_valid_next = 1'b0;
                    if (final_result)
                    begin
                        count_next = '0;
                        dot_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            dot_reg          <= '0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            dot_reg          <= dot_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Element stores with registered read.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            prob_mem[count_reg[ADDR_W-1:0]] <= prob;
            grad_mem[count_reg[ADDR_W-1:0]] <= grad_in;
        end
        if (state_reg == S_RD)
        begin
            rd_prob_reg <= prob_mem[idx_reg[ADDR_W-1:0]];
            rd_grad_reg <= grad_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            y_reg <= prob;
            g_reg <= grad_in;
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= grad_scaled - dot_reg;
        end
        if (state_reg == S_MHI)
        begin
            lo_reg <= mul_p;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= (hi_ext << LO_W) + lo_ext;
        end
        if (state_reg == S_SCALE)
        begin
            last_out_reg <= final_result;
            if (rounded > OUT_MAX)
            begin
                grad_out_reg <= OUT_MAX[OUT_W-1:0];
                sat_reg      <= 1'b1;
            end
            else if (rounded < OUT_MIN)
            begin
                grad_out_reg <= OUT_MIN[OUT_W-1:0];
                sat_reg      <= 1'b1;
            end
            else
            begin
                grad_out_reg <= rounded[OUT_W-1:0];
                sat_reg      <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign grad_out     = grad_out_reg;
    assign last_out     = last_out_reg;
    assign saturated    = sat_reg;

    // The two channels never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
    else $error("item channel open while a result is pending");

    // A result always refers to a stored element.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (idx_reg < count_reg))
    else $error("result index outside the stored elements");

    // The final result of a vector returns the block to an empty state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && last_out) |=>
            (count_reg == '0 && dot_reg == '0 && item_ready))
    else $error("vector state not cleared after the final result");

    // The element count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CHANNELS))
    else $error("element count beyond store depth");

endmodule
